[src/cmst_pkg.sv]
// ============================================================================
// cmst_pkg: comment stripper shared types and constants
// Item structs for both channels, character codes and the result slot group
// handed from the stripping logic to the output queue.
// ============================================================================
package cmst_pkg;

    // Character codes that drive the stripping stages
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Most results one input item can produce
    localparam int CMST_MAX_RESULTS = 3;

    // Default depth of the output queue
    localparam int CMST_FIFO_DEPTH = 4;

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       last;
    } t_out_item;

    // Results of one input item, packed from slot 0 upward
    typedef struct packed {
        logic [1:0]                           cnt;
        t_out_item [CMST_MAX_RESULTS-1:0]     items;
    } t_slots;

endpackage

[src/cmst_step.sv]
// ============================================================================
// cmst_step: two-stage comment stripping logic
// Holds the line stage and block stage modes and turns one accepted byte
// into up to three result items through combinational logic.
// ============================================================================
module cmst_step
    import cmst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_item i_item,
    output t_slots   o_slots
);

    typedef enum logic [1:0] {
        LM_NORMAL  = 2'd0,
        LM_SLASH   = 2'd1,
        LM_COMMENT = 2'd2
    } t_line_mode;

    typedef enum logic [1:0] {
        BM_NORMAL = 2'd0,
        BM_SLASH  = 2'd1,
        BM_BLOCK  = 2'd2,
        BM_STAR   = 2'd3
    } t_block_mode;

    // Outcome of one byte fed into the block stage
    typedef struct packed {
        t_block_mode mode;
        logic [1:0]  cnt;
        logic [7:0]  b0;
        logic [7:0]  b1;
    } t_blk_res;

    t_line_mode  r_line_mode;
    t_line_mode  n_line_mode;
    t_block_mode r_block_mode;
    t_block_mode n_block_mode;
    t_slots      n_slots;

    // Block stage: one byte in, zero to two bytes out
    function automatic t_blk_res blk_feed(t_block_mode m, logic [7:0] b);
        t_blk_res r;
        r.mode = m;
        r.cnt  = 2'd0;
        r.b0   = b;
        r.b1   = b;
        case (m)
            BM_SLASH: begin
                if (b == CH_STAR) begin
                    r.mode = BM_STAR;
                end else if (b == CH_SLASH) begin
                    // first slash goes out, second one stays held
                    r.cnt = 2'd1;
                    r.b0  = CH_SLASH;
                end else begin
                    r.cnt  = 2'd2;
                    r.b0   = CH_SLASH;
                    r.b1   = b;
                    r.mode = BM_NORMAL;
                end
            end
            BM_BLOCK: begin
                if (b == CH_STAR) begin
                    r.mode = BM_STAR;
                end
            end
            BM_STAR: begin
                if (b == CH_SLASH) begin
                    r.mode = BM_NORMAL;
                end else if (b != CH_STAR) begin
                    r.mode = BM_BLOCK;
                end
            end
            default: begin
                if (b == CH_SLASH) begin
                    r.mode = BM_SLASH;
                end else begin
                    r.cnt = 2'd1;
                end
            end
        endcase
        return r;
    endfunction

    // Append one byte; anything past the third slot is dropped
    function automatic t_slots slot_push(t_slots s, logic [7:0] b);
        t_slots t;
        t = s;
        if (t.cnt != 2'd3) begin
            t.items[t.cnt] = t_out_item'({b, 1'b1, 1'b0});
            t.cnt          = t.cnt + 2'd1;
        end
        return t;
    endfunction

    function automatic t_slots slot_push_blk(t_slots s, t_blk_res r);
        t_slots t;
        t = s;
        if (r.cnt != 2'd0) begin
            t = slot_push(t, r.b0);
        end
        if (r.cnt == 2'd2) begin
            t = slot_push(t, r.b1);
        end
        return t;
    endfunction

    // Line stage, then block stage, then end-of-text flush
    always_comb begin : p_step
        t_blk_res   r1;
        t_blk_res   r2;
        t_blk_res   r3;
        t_slots     s;
        logic [7:0] b;
        s            = '0;
        r1           = '0;
        r2           = '0;
        r3           = '0;
        b            = i_item.in_byte;
        n_line_mode  = r_line_mode;
        n_block_mode = r_block_mode;

        case (r_line_mode)
            LM_SLASH: begin
                if (b == CH_SLASH) begin
                    n_line_mode = LM_COMMENT;
                end else begin
                    // release the held slash, then this byte
                    n_line_mode  = LM_NORMAL;
                    r1           = blk_feed(r_block_mode, CH_SLASH);
                    s            = slot_push_blk(s, r1);
                    r2           = blk_feed(r1.mode, b);
                    s            = slot_push_blk(s, r2);
                    n_block_mode = r2.mode;
                end
            end
            LM_COMMENT: begin
                if (b == CH_NEWLINE) begin
                    n_line_mode  = LM_NORMAL;
                    r1           = blk_feed(r_block_mode, b);
                    s            = slot_push_blk(s, r1);
                    n_block_mode = r1.mode;
                end
            end
            default: begin
                if (b == CH_SLASH) begin
                    n_line_mode = LM_SLASH;
                end else begin
                    n_line_mode  = LM_NORMAL;
                    r1           = blk_feed(r_block_mode, b);
                    s            = slot_push_blk(s, r1);
                    n_block_mode = r1.mode;
                end
            end
        endcase

        if (i_item.end_of_text) begin
            if (n_line_mode == LM_SLASH) begin
                r3           = blk_feed(n_block_mode, CH_SLASH);
                s            = slot_push_blk(s, r3);
                n_block_mode = r3.mode;
            end
            n_line_mode = LM_NORMAL;
            if (n_block_mode == BM_SLASH) begin
                s = slot_push(s, CH_SLASH);
            end
            n_block_mode = BM_NORMAL;
            // empty end marker
            if (s.cnt == 2'd0) begin
                s.items[0] = '0;
                s.cnt      = 2'd1;
            end
            s.items[s.cnt - 2'd1].last = 1'b1;
        end
        n_slots = s;
    end

    // Stage modes advance on every accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mode  <= LM_NORMAL;
            r_block_mode <= BM_NORMAL;
        end else if (i_take) begin
            r_line_mode  <= n_line_mode;
            r_block_mode <= n_block_mode;
        end
    end

    assign o_slots = n_slots;

endmodule

[src/comment_stripper.sv]
// ============================================================================
// comment_stripper: C-style comment removal on a byte stream
// Strips line comments, then block comments, from text fed one byte per
// item, and queues the surviving bytes for the output channel.
// ============================================================================
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ---------------------------------
//  input    in         i_valid / o_ready    i_data : t_in_item  (byte, eot)
//  output   out        o_valid / i_ready    o_data : t_out_item (byte, has, last)
//
//  One input item is accepted per cycle while o_ready is high; its zero to
//  three result items are written into the output queue at the same clock
//  edge, so the first one is in the queue in the cycle after acceptance.
//  o_ready is high while the queue has room for three results; at the default
//  depth of four, a stream giving one result per item while i_ready stays high
//  never stalls. Reset (synchronous, active low) returns both stages to normal
//  mode and empties the queue. A stalled output holds its item until it is taken.
//
module comment_stripper
    import cmst_pkg::*;
#(
    parameter int FIFO_DEPTH = CMST_FIFO_DEPTH   // 4 .. 32
)(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_out_item         r_mem [FIFO_DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     n_wr;
    logic [AW-1:0]     r_rd;
    logic [AW-1:0]     n_rd;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              take;
    logic              pop;
    logic [1:0]        push_n;
    t_slots            slots;

    // Queue pointer advance with wrap at the depth
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] p, logic [1:0] k);
        logic [AW:0] s;
        s = {1'b0, p} + (AW+1)'(k);
        if (s >= (AW+1)'(FIFO_DEPTH)) begin
            s = s - (AW+1)'(FIFO_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    cmst_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_data),
        .o_slots (slots)
    );

    // Handshakes
    assign o_ready = (r_count <= CW'(FIFO_DEPTH - CMST_MAX_RESULTS));
    assign take    = i_valid && o_ready;
    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rd];

    // Queue bookkeeping
    assign push_n  = take ? slots.cnt : 2'd0;
    assign n_wr    = wrap_add(r_wr, push_n);
    assign n_rd    = pop ? wrap_add(r_rd, 2'd1) : r_rd;
    assign n_count = r_count + CW'(push_n) - CW'(pop);

    // Result storage: up to three writes per cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CMST_MAX_RESULTS; k++) begin
            if (take && (2'(k) < slots.cnt)) begin
                r_mem[wrap_add(r_wr, 2'(k))] <= slots.items[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

[src/cmst_checker.sv]
// ============================================================================
// cmst_checker: port-level checks for comment_stripper
// Watches the top-level ports only and is attached by a bind statement.
// ============================================================================
module cmst_checker
    import cmst_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);

    // A stalled result item holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output item changed or dropped while stalled");

    // An item without a byte is only the end marker
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_byte |-> o_data.last)
        else $error("empty item that is not the last of the text");

    // The end marker carries a zero byte
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.has_byte |-> o_data.out_byte == 8'd0)
        else $error("empty item carries a nonzero byte");

    // Input only backs up behind queued results
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with nothing queued");

endmodule

bind comment_stripper cmst_checker u_cmst_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
